// ----- rtl/core/plvs_pkg.sv -----
// shared types and constants for the point light vertex shade core
// no dependencies
`default_nettype none

package plvs_pkg;

    localparam int INTENSITY_FRAC_BITS = 8;
    localparam int ROOT_W = 17;
    localparam int D2_W = 2 * ROOT_W;
    localparam int QUOT_W = 8;
    localparam int PROD_W = 32;
    localparam int PART_W = PROD_W - INTENSITY_FRAC_BITS;
    localparam logic [8:0] INTENSITY_ONE = 9'(1 << INTENSITY_FRAC_BITS);
    localparam logic [8:0] CHAN_MAX = 9'd255;

    typedef enum logic [2:0] {
        REG_LIGHT_X      = 3'd0,
        REG_LIGHT_Y      = 3'd1,
        REG_INNER_RADIUS = 3'd2,
        REG_OUTER_RADIUS = 3'd3,
        REG_LIGHT_RED    = 3'd4,
        REG_LIGHT_GREEN  = 3'd5,
        REG_LIGHT_BLUE   = 3'd6,
        REG_INTENSITY    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        outer;
        logic        full;
        logic [31:0] color;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/point_light_vertex_shade_core.sv -----
// point light vertex shade core: distance, falloff and color blend pipeline
// depends on plvs_pkg and plvs_isqrt
`default_nettype none

// channel  direction  fields (lsb first)
// s_*      in         vertex_x[15:0] vertex_y[31:16] base_color[63:32]
// m_*      out        shaded_color[31:0]
// cfg_*    in         index 0..7, data up to 16 bits
//
// one item per cycle while the output is not stalled
// 31 register stages: 3 distance, 17 root, 2 product, 8 quotient, 1 output
// one global enable: a stalled output freezes every stage
// reset clears valid bits and sets the configuration registers to their reset values

module point_light_vertex_shade_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // vertex_x, vertex_y, base_color
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // shaded_color
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int FB = plvs_pkg::INTENSITY_FRAC_BITS;
    localparam int QW = plvs_pkg::QUOT_W;
    localparam int PW = plvs_pkg::PART_W;

    // configuration
    logic signed [15:0] light_x_reg, light_y_reg;
    logic [15:0] inner_reg, outer_reg;
    logic [7:0]  lc_reg [0:2];
    logic [8:0]  intensity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg   <= '0;
            light_y_reg   <= '0;
            inner_reg     <= '0;
            outer_reg     <= '0;
            lc_reg[0]     <= '0;
            lc_reg[1]     <= '0;
            lc_reg[2]     <= '0;
            intensity_reg <= plvs_pkg::INTENSITY_ONE;
        end
        else if (cfg_we)
        begin
            case (plvs_pkg::cfg_reg_t'(cfg_index))
                plvs_pkg::REG_LIGHT_X:      light_x_reg   <= cfg_data;
                plvs_pkg::REG_LIGHT_Y:      light_y_reg   <= cfg_data;
                plvs_pkg::REG_INNER_RADIUS: inner_reg     <= cfg_data;
                plvs_pkg::REG_OUTER_RADIUS: outer_reg     <= cfg_data;
                plvs_pkg::REG_LIGHT_RED:    lc_reg[0]     <= cfg_data[7:0];
                plvs_pkg::REG_LIGHT_GREEN:  lc_reg[1]     <= cfg_data[7:0];
                plvs_pkg::REG_LIGHT_BLUE:   lc_reg[2]     <= cfg_data[7:0];
                plvs_pkg::REG_INTENSITY:    intensity_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // values derived from configuration
    logic [8:0]  inten_reg;
    logic [31:0] outer_sq_reg, inner_sq_reg;
    logic [15:0] diff_reg;
    logic        equal_reg;
    logic [15:0] lci_reg [0:2];

    always_ff @(posedge clk)
    begin
        inten_reg    <= (intensity_reg > plvs_pkg::INTENSITY_ONE) ?
                        plvs_pkg::INTENSITY_ONE : intensity_reg;
        outer_sq_reg <= outer_reg * outer_reg;
        inner_sq_reg <= inner_reg * inner_reg;
        diff_reg     <= outer_reg - inner_reg;
        equal_reg    <= (outer_reg <= inner_reg);
        for (int i = 0; i < 3; i++)
        begin
            lci_reg[i] <= 16'({8'd0, lc_reg[i]} * {7'd0, inten_reg});
        end
    end

    logic ce;
    logic out_valid_reg;
    logic [31:0] out_data_reg;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // stage 1: differences
    logic        v1_reg;
    logic [16:0] dx_reg, dy_reg;
    logic [31:0] c1_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dx_reg <= {s_tdata[15], s_tdata[15:0]} - {light_x_reg[15], light_x_reg};
            dy_reg <= {s_tdata[31], s_tdata[31:16]} - {light_y_reg[15], light_y_reg};
            c1_reg <= s_tdata[63:32];
        end
    end

    // stage 2: squares
    logic        v2_reg;
    logic [31:0] sqx_reg, sqy_reg;
    logic [31:0] c2_reg;
    logic [16:0] adx, ady;

    always_comb
    begin
        adx = dx_reg[16] ? 17'(-dx_reg) : dx_reg;
        ady = dy_reg[16] ? 17'(-dy_reg) : dy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sqx_reg <= adx[15:0] * adx[15:0];
            sqy_reg <= ady[15:0] * ady[15:0];
            c2_reg  <= c1_reg;
        end
    end

    // stage 3: distance squared and region
    logic                          v3_reg;
    logic [plvs_pkg::D2_W-1:0]     d2_reg;
    plvs_pkg::side_t               s3_reg;
    logic [plvs_pkg::D2_W-1:0]     d2_next;

    assign d2_next = {2'b00, sqx_reg} + {2'b00, sqy_reg};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d2_reg       <= d2_next;
            s3_reg.outer <= (d2_next > {2'b00, outer_sq_reg});
            s3_reg.full  <= (d2_next < {2'b00, inner_sq_reg}) || equal_reg;
            s3_reg.color <= c2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    logic                        vr;
    logic [plvs_pkg::ROOT_W-1:0] root_val;
    plvs_pkg::side_t             sr;

    plvs_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v3_reg),
        .in_d2     (d2_reg),
        .in_side   (s3_reg),
        .out_valid (vr),
        .out_root  (root_val),
        .out_side  (sr)
    );

    // remaining distance to the outer radius
    logic            vn_reg;
    logic [15:0]     num_reg;
    plvs_pkg::side_t sn_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num_reg <= (root_val < {1'b0, outer_reg}) ?
                       16'({1'b0, outer_reg} - root_val) : '0;
            sn_reg  <= sr;
        end
    end

    // product of light color, intensity and remaining distance
    logic            vm_reg;
    logic [plvs_pkg::PROD_W-1:0] prod_reg [0:2];
    plvs_pkg::side_t sm_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= lci_reg[i] * num_reg;
            end
            sm_reg <= sn_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg <= 1'b0;
            vm_reg <= 1'b0;
        end
        else if (ce)
        begin
            vn_reg <= vr;
            vm_reg <= vn_reg;
        end
    end

    // restoring division by the radius span, one quotient bit per stage
    logic            vq_reg  [0:QW-1];
    logic [PW-1:0]   rq_reg  [0:QW-1][0:2];
    logic [QW-1:0]   qq_reg  [0:QW-1][0:2];
    plvs_pkg::side_t sq_reg  [0:QW-1];

    genvar k, c;
    generate
        for (k = 0; k < QW; k++)
        begin : g_div
            logic            pv;
            plvs_pkg::side_t ps;
            logic [PW-1:0]   shifted;

            assign shifted = PW'({{(PW-16){1'b0}}, diff_reg} << (QW - 1 - k));

            if (k == 0)
            begin : g_first
                assign pv = vm_reg;
                assign ps = sm_reg;
            end
            else
            begin : g_next
                assign pv = vq_reg[k-1];
                assign ps = sq_reg[k-1];
            end

            for (c = 0; c < 3; c++)
            begin : g_lane
                logic [PW-1:0] pr;
                logic [QW-1:0] pq;
                logic          take;

                if (k == 0)
                begin : g_first
                    assign pr = prod_reg[c][FB +: PW];
                    assign pq = '0;
                end
                else
                begin : g_next
                    assign pr = rq_reg[k-1][c];
                    assign pq = qq_reg[k-1][c];
                end

                assign take = (pr >= shifted);

                always_ff @(posedge clk)
                begin
                    if (ce)
                    begin
                        rq_reg[k][c] <= take ? PW'(pr - shifted) : pr;
                        qq_reg[k][c] <= {pq[QW-2:0], take};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vq_reg[k] <= 1'b0;
                end
                else if (ce)
                begin
                    vq_reg[k] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    sq_reg[k] <= ps;
                end
            end
        end
    endgenerate

    // final blend
    plvs_pkg::side_t sf;
    logic [31:0]     out_next;
    logic [7:0]      ch   [0:2];
    logic [16:0]     scl  [0:2];
    logic [7:0]      addv [0:2];
    logic [8:0]      sum  [0:2];
    logic [7:0]      res  [0:2];

    assign sf = sq_reg[QW-1];

    always_comb
    begin
        ch[0] = sf.color[23:16];
        ch[1] = sf.color[15:8];
        ch[2] = sf.color[7:0];
        for (int i = 0; i < 3; i++)
        begin
            scl[i]  = {9'd0, ch[i]} * {8'd0, inten_reg};
            addv[i] = sf.full ? lci_reg[i][FB +: 8] : qq_reg[QW-1][i];
            sum[i]  = {1'b0, ch[i]} + {1'b0, addv[i]};
            if (sf.outer)
            begin
                res[i] = scl[i][FB +: 8];
            end
            else
            begin
                res[i] = (sum[i] > plvs_pkg::CHAN_MAX) ? 8'hff : sum[i][7:0];
            end
        end
        out_next = {sf.color[31:24], res[0], res[1], res[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= vq_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/plvs_isqrt.sv -----
// pipelined integer square root, one root bit per stage
// depends on plvs_pkg
`default_nettype none

module plvs_isqrt
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            ce,
    input  wire logic                            in_valid,
    input  wire logic [plvs_pkg::D2_W-1:0]       in_d2,
    input  wire plvs_pkg::side_t                 in_side,
    output logic                                 out_valid,
    output logic [plvs_pkg::ROOT_W-1:0]          out_root,
    output plvs_pkg::side_t                      out_side
);

    localparam int N = plvs_pkg::ROOT_W;
    localparam int REM_W = N + 2;

    logic                 valid_reg [0:N-1];
    logic [REM_W-1:0]     rem_reg   [0:N-1];
    logic [N-1:0]         root_reg  [0:N-1];
    logic [plvs_pkg::D2_W-1:0] rad_reg [0:N-1];
    plvs_pkg::side_t      side_reg  [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic                      prev_valid;
            logic [REM_W-1:0]          prev_rem;
            logic [N-1:0]              prev_root;
            logic [plvs_pkg::D2_W-1:0] prev_rad;
            plvs_pkg::side_t           prev_side;
            logic [REM_W+1:0]          rem_shift;
            logic [REM_W+1:0]          trial;
            logic                      take;
            logic [REM_W-1:0]          rem_next;
            logic [N-1:0]              root_next;

            if (k == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_rem   = '0;
                assign prev_root  = '0;
                assign prev_rad   = in_d2;
                assign prev_side  = in_side;
            end
            else
            begin : g_next
                assign prev_valid = valid_reg[k-1];
                assign prev_rem   = rem_reg[k-1];
                assign prev_root  = root_reg[k-1];
                assign prev_rad   = rad_reg[k-1];
                assign prev_side  = side_reg[k-1];
            end

            always_comb
            begin
                rem_shift = {prev_rem, prev_rad[plvs_pkg::D2_W-1 -: 2]};
                trial     = {2'b00, prev_root, 2'b01};
                take      = (rem_shift >= trial);
                rem_next  = take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
                root_next = {prev_root[N-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (ce)
                begin
                    valid_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    rad_reg[k]  <= {prev_rad[plvs_pkg::D2_W-3:0], 2'b00};
                    side_reg[k] <= prev_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ----- rtl/core/plvs_checker.sv -----
// port checks for the point light vertex shade core
// bound to point_light_vertex_shade_core
`default_nettype none

module plvs_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("output appeared while pipeline frozen");

endmodule

bind point_light_vertex_shade_core plvs_checker u_plvs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
